@@ src/ljq_pkg.sv @@
// ----------------------------------------------------------------------------
// ljq_pkg
// Shared types, sizes, command and status codes for the leased job queue.
// ----------------------------------------------------------------------------
package ljq_pkg;

  // Sizes of the stores and of the fields.
  localparam int unsigned JOB_CAPACITY = 64;
  localparam int unsigned ID_BITS      = 16;
  localparam int unsigned IDX_W        = $clog2(JOB_CAPACITY);
  localparam int unsigned CNT_W        = $clog2(JOB_CAPACITY + 1);
  localparam int unsigned TIME_W       = 48;
  localparam int unsigned TICK_W       = 16;
  localparam int unsigned JOB_W        = 16;
  localparam int unsigned CMD_W        = 3;
  localparam int unsigned STATUS_W     = 3;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [TIME_W-1:0]  time_t;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ENQUEUE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEQUEUE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ACK      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REQUEUE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SIZE     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd5;
  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd6;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LEASED     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_QUEUED     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_LEASED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;

  // Requests from the controller to the lease store.
  typedef struct packed {
    logic  rd_en;
    idx_t  rd_addr;
    logic  wr_en;
    idx_t  wr_addr;
    id_t   wr_id;
    time_t wr_deadline;
    logic  clr_en;
    idx_t  clr_addr;
  } lease_req_t;

  // Ring index plus an offset, wrapped at the capacity.
  function automatic idx_t idx_add(idx_t a, cnt_t b);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
    if (s >= (CNT_W+1)'(JOB_CAPACITY)) begin
      s = s - (CNT_W+1)'(JOB_CAPACITY);
    end
    return idx_t'(s);
  endfunction

endpackage

@@ src/leased_job_queue_core.sv @@
// ----------------------------------------------------------------------------
// leased_job_queue_core
// Job dispatcher with a ring of waiting ids and a table of timed leases.
// ----------------------------------------------------------------------------
// One command is taken at a time and gives one result beat. Each lookup walks
// a memory one entry per cycle through its single read port, so the time per
// command is set by those walks: tick and unknown commands walk nothing;
// acknowledge and requeue walk the lease table once; enqueue and contains walk
// it and then, unless the id is leased, the waiting ids. Dequeue and size walk
// the lease table once for every expired lease plus once more. A new command
// is taken as soon as the previous result has moved to the output register,
// even while that beat still waits.
module leased_job_queue_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [15:0] job_id_i,
  input  logic [15:0] lease_ticks_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        found_o,
  output logic [15:0] job_out_o,
  output logic        job_valid_o,
  output logic [6:0]  pending_count_o,
  output logic [6:0]  leased_count_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LSCAN = 3'd1;
  localparam logic [2:0] S_PSCAN = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_DEQ   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam ljq_pkg::cnt_t CAP = ljq_pkg::cnt_t'(ljq_pkg::JOB_CAPACITY);
  localparam ljq_pkg::time_t TIME_MAX = '1;

  logic [2:0] state_q, state_d;
  logic [ljq_pkg::CMD_W-1:0] cmd_q, cmd_d;
  ljq_pkg::id_t  id_q, id_d;
  logic [ljq_pkg::TICK_W-1:0] ticks_q, ticks_d;
  ljq_pkg::time_t time_q, time_d;
  ljq_pkg::idx_t head_q, head_d;
  ljq_pkg::cnt_t total_q, total_d;

  // Walk control.
  ljq_pkg::cnt_t idx_q, idx_d;
  logic          rv_q, rv_d;
  ljq_pkg::idx_t ridx_q, ridx_d;
  logic          hit_q, hit_d;
  ljq_pkg::idx_t hit_slot_q, hit_slot_d;
  logic          best_q, best_d;
  ljq_pkg::id_t  best_id_q, best_id_d;
  ljq_pkg::idx_t best_slot_q, best_slot_d;

  // Staged result.
  logic [ljq_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic                         res_found_q, res_found_d;
  ljq_pkg::id_t                 res_job_q, res_job_d;
  logic                         res_jv_q, res_jv_d;

  // Output register.
  logic                         out_valid_q, out_valid_d;
  logic                         out_load;
  logic [ljq_pkg::STATUS_W-1:0] o_status_q;
  logic                         o_found_q;
  ljq_pkg::id_t                 o_job_q;
  logic                         o_jv_q;
  ljq_pkg::cnt_t                o_pend_q, o_lease_q;

  // Pending ring memory.
  ljq_pkg::id_t  pmem [ljq_pkg::JOB_CAPACITY];
  ljq_pkg::id_t  prd_q;
  logic          pm_rd_en, pm_wr_en;
  ljq_pkg::idx_t pm_rd_addr, pm_wr_addr;
  ljq_pkg::id_t  pm_wr_data;

  // Lease store.
  ljq_pkg::lease_req_t lreq;
  ljq_pkg::id_t        l_rd_id;
  ljq_pkg::time_t      l_rd_dl;
  logic                l_rd_valid;
  ljq_pkg::idx_t       l_free;
  ljq_pkg::cnt_t       l_count;

  logic                    accept;
  logic                    issue;
  logic [ljq_pkg::CNT_W:0] occupancy;
  logic [ljq_pkg::TIME_W:0] dl_sum;
  ljq_pkg::time_t          deadline;
  ljq_pkg::idx_t           head_m1;

  ljq_lease_store u_lease (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (lreq),
    .rd_id_o        (l_rd_id),
    .rd_deadline_o  (l_rd_dl),
    .rd_valid_o     (l_rd_valid),
    .free_slot_o    (l_free),
    .leased_count_o (l_count)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign occupancy  = (ljq_pkg::CNT_W+1)'(total_q) + (ljq_pkg::CNT_W+1)'(l_count);
  assign dl_sum     = (ljq_pkg::TIME_W+1)'(time_q) + (ljq_pkg::TIME_W+1)'(ticks_q);
  assign deadline   = dl_sum[ljq_pkg::TIME_W] ? TIME_MAX : dl_sum[ljq_pkg::TIME_W-1:0];
  assign head_m1    = (head_q == '0) ? ljq_pkg::idx_t'(ljq_pkg::JOB_CAPACITY - 1)
                                     : head_q - ljq_pkg::idx_t'(1);

  // Pending ring: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (pm_wr_en) begin
      pmem[pm_wr_addr] <= pm_wr_data;
    end
    if (pm_rd_en) begin
      prd_q <= pmem[pm_rd_addr];
    end
  end

  // Command sequencer.
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    id_d         = id_q;
    ticks_d      = ticks_q;
    time_d       = time_q;
    head_d       = head_q;
    total_d      = total_q;
    idx_d        = idx_q;
    rv_d         = 1'b0;
    ridx_d       = ridx_q;
    hit_d        = hit_q;
    hit_slot_d   = hit_slot_q;
    best_d       = best_q;
    best_id_d    = best_id_q;
    best_slot_d  = best_slot_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_job_d    = res_job_q;
    res_jv_d     = res_jv_q;
    out_load     = 1'b0;
    issue        = 1'b0;
    pm_rd_en     = 1'b0;
    pm_rd_addr   = head_q;
    pm_wr_en     = 1'b0;
    pm_wr_addr   = head_q;
    pm_wr_data   = id_q;
    lreq         = '0;
    lreq.wr_deadline = deadline;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d        = cmd_i;
          id_d         = job_id_i[ljq_pkg::ID_BITS-1:0];
          ticks_d      = lease_ticks_i;
          idx_d        = '0;
          hit_d        = 1'b0;
          best_d       = 1'b0;
          res_status_d = ljq_pkg::ST_OK;
          res_found_d  = 1'b0;
          res_job_d    = '0;
          res_jv_d     = 1'b0;
          unique case (cmd_i) inside
            ljq_pkg::CMD_ENQUEUE, ljq_pkg::CMD_ACK, ljq_pkg::CMD_REQUEUE,
            ljq_pkg::CMD_CONTAINS: state_d = S_LSCAN;
            ljq_pkg::CMD_DEQUEUE, ljq_pkg::CMD_SIZE: state_d = S_SWEEP;
            ljq_pkg::CMD_TICK: begin
              if (time_q != TIME_MAX) begin
                time_d = time_q + ljq_pkg::time_t'(1);
              end
              state_d = S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      // Walk the lease table looking for the command's id.
      S_LSCAN: begin
        issue         = (idx_q < CAP);
        lreq.rd_en    = issue;
        lreq.rd_addr  = idx_q[ljq_pkg::IDX_W-1:0];
        if (issue) begin
          idx_d  = idx_q + ljq_pkg::cnt_t'(1);
          rv_d   = 1'b1;
          ridx_d = idx_q[ljq_pkg::IDX_W-1:0];
        end
        if (rv_q && l_rd_valid && (l_rd_id == id_q) && !hit_q) begin
          hit_d      = 1'b1;
          hit_slot_d = ridx_q;
        end
        if (!issue && !rv_q) begin
          case (cmd_q)
            ljq_pkg::CMD_ENQUEUE: begin
              if (hit_q) begin
                res_status_d = ljq_pkg::ST_LEASED;
                state_d      = S_DONE;
              end else begin
                idx_d   = '0;
                state_d = S_PSCAN;
              end
            end
            ljq_pkg::CMD_CONTAINS: begin
              if (hit_q) begin
                res_found_d = 1'b1;
                state_d     = S_DONE;
              end else begin
                idx_d   = '0;
                state_d = S_PSCAN;
              end
            end
            default: begin
              // Acknowledge and requeue.
              if (hit_q) begin
                lreq.clr_en   = 1'b1;
                lreq.clr_addr = hit_slot_q;
                if (cmd_q == ljq_pkg::CMD_REQUEUE && total_q < CAP) begin
                  head_d     = head_m1;
                  pm_wr_en   = 1'b1;
                  pm_wr_addr = head_m1;
                  pm_wr_data = id_q;
                  total_d    = total_q + ljq_pkg::cnt_t'(1);
                end
              end else begin
                res_status_d = ljq_pkg::ST_NOT_LEASED;
              end
              state_d = S_DONE;
            end
          endcase
        end
      end

      // Walk the waiting ids from the front.
      S_PSCAN: begin
        issue      = (idx_q < total_q);
        pm_rd_en   = issue;
        pm_rd_addr = ljq_pkg::idx_add(head_q, idx_q);
        if (issue) begin
          idx_d = idx_q + ljq_pkg::cnt_t'(1);
          rv_d  = 1'b1;
        end
        if (rv_q && (prd_q == id_q)) begin
          hit_d = 1'b1;
        end
        if (!issue && !rv_q) begin
          if (cmd_q == ljq_pkg::CMD_CONTAINS) begin
            res_found_d = hit_q;
          end else if (hit_q) begin
            res_status_d = ljq_pkg::ST_QUEUED;
          end else if (occupancy >= (ljq_pkg::CNT_W+1)'(ljq_pkg::JOB_CAPACITY)) begin
            res_status_d = ljq_pkg::ST_FULL;
          end else begin
            pm_wr_en   = 1'b1;
            pm_wr_addr = ljq_pkg::idx_add(head_q, total_q);
            pm_wr_data = id_q;
            total_d    = total_q + ljq_pkg::cnt_t'(1);
          end
          state_d = S_DONE;
        end
      end

      // Find the smallest expired id; return it to the front if the ring has room, and walk again.
      S_SWEEP: begin
        issue        = (idx_q < CAP);
        lreq.rd_en   = issue;
        lreq.rd_addr = idx_q[ljq_pkg::IDX_W-1:0];
        if (issue) begin
          idx_d  = idx_q + ljq_pkg::cnt_t'(1);
          rv_d   = 1'b1;
          ridx_d = idx_q[ljq_pkg::IDX_W-1:0];
        end
        if (rv_q && l_rd_valid && (l_rd_dl <= time_q) &&
            (!best_q || (l_rd_id < best_id_q))) begin
          best_d      = 1'b1;
          best_id_d   = l_rd_id;
          best_slot_d = ridx_q;
        end
        if (!issue && !rv_q) begin
          if (best_q) begin
            lreq.clr_en   = 1'b1;
            lreq.clr_addr = best_slot_q;
            if (total_q < CAP) begin
              head_d     = head_m1;
              pm_wr_en   = 1'b1;
              pm_wr_addr = head_m1;
              pm_wr_data = best_id_q;
              total_d    = total_q + ljq_pkg::cnt_t'(1);
            end
            idx_d  = '0;
            best_d = 1'b0;
          end else if (cmd_q == ljq_pkg::CMD_SIZE) begin
            state_d = S_DONE;
          end else if (total_q == '0) begin
            res_status_d = ljq_pkg::ST_EMPTY;
            state_d      = S_DONE;
          end else begin
            pm_rd_en   = 1'b1;
            pm_rd_addr = head_q;
            state_d    = S_DEQ;
          end
        end
      end

      // Front id is in the read register: lease it out.
      S_DEQ: begin
        lreq.wr_en   = 1'b1;
        lreq.wr_addr = l_free;
        lreq.wr_id   = prd_q;
        head_d       = ljq_pkg::idx_add(head_q, ljq_pkg::cnt_t'(1));
        total_d      = total_q - ljq_pkg::cnt_t'(1);
        res_job_d    = prd_q;
        res_jv_d     = 1'b1;
        state_d      = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Output beat handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      time_q      <= '0;
      head_q      <= '0;
      total_q     <= '0;
      idx_q       <= '0;
      rv_q        <= 1'b0;
      hit_q       <= 1'b0;
      best_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      time_q      <= time_d;
      head_q      <= head_d;
      total_q     <= total_d;
      idx_q       <= idx_d;
      rv_q        <= rv_d;
      hit_q       <= hit_d;
      best_q      <= best_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    id_q         <= id_d;
    ticks_q      <= ticks_d;
    ridx_q       <= ridx_d;
    hit_slot_q   <= hit_slot_d;
    best_id_q    <= best_id_d;
    best_slot_q  <= best_slot_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_job_q    <= res_job_d;
    res_jv_q     <= res_jv_d;
    if (out_load) begin
      o_status_q <= res_status_q;
      o_found_q  <= res_found_q;
      o_job_q    <= res_job_q;
      o_jv_q     <= res_jv_q;
      o_pend_q   <= total_q;
      o_lease_q  <= l_count;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = o_status_q;
  assign found_o         = o_found_q;
  assign job_out_o       = 16'(o_job_q);
  assign job_valid_o     = o_jv_q;
  assign pending_count_o = 7'(o_pend_q);
  assign leased_count_o  = 7'(o_lease_q);

endmodule

@@ src/ljq_lease_store.sv @@
// ----------------------------------------------------------------------------
// ljq_lease_store
// Lease table: id and deadline memory with a registered read port, valid
// bits in flip-flops, the first free slot and the number of leases held.
// ----------------------------------------------------------------------------
module ljq_lease_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ljq_pkg::lease_req_t req_i,
  output ljq_pkg::id_t        rd_id_o,
  output ljq_pkg::time_t      rd_deadline_o,
  output logic                rd_valid_o,
  output ljq_pkg::idx_t       free_slot_o,
  output ljq_pkg::cnt_t       leased_count_o
);

  ljq_pkg::id_t   id_mem [ljq_pkg::JOB_CAPACITY];
  ljq_pkg::time_t dl_mem [ljq_pkg::JOB_CAPACITY];

  ljq_pkg::id_t                     rd_id_q;
  ljq_pkg::time_t                   rd_dl_q;
  logic                             rd_valid_q;
  logic [ljq_pkg::JOB_CAPACITY-1:0] valid_q, valid_d;
  ljq_pkg::cnt_t                    count_q, count_d;
  ljq_pkg::idx_t                    free_slot;

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      id_mem[req_i.wr_addr] <= req_i.wr_id;
      dl_mem[req_i.wr_addr] <= req_i.wr_deadline;
    end
    if (req_i.rd_en) begin
      rd_id_q <= id_mem[req_i.rd_addr];
      rd_dl_q <= dl_mem[req_i.rd_addr];
    end
  end

  // Valid bits and lease count follow writes and clears.
  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    if (req_i.wr_en) begin
      valid_d[req_i.wr_addr] = 1'b1;
      count_d = count_d + ljq_pkg::cnt_t'(1);
    end
    if (req_i.clr_en) begin
      valid_d[req_i.clr_addr] = 1'b0;
      count_d = count_d - ljq_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      count_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  // Lowest free slot.
  always_comb begin
    free_slot = '0;
    for (int i = ljq_pkg::JOB_CAPACITY - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = ljq_pkg::idx_t'(i);
      end
    end
  end

  assign rd_id_o        = rd_id_q;
  assign rd_deadline_o  = rd_dl_q;
  assign rd_valid_o     = rd_valid_q;
  assign free_slot_o    = free_slot;
  assign leased_count_o = count_q;

endmodule
